[hw/rtl/soft_disk_pair_force_top_assert.svh]
// Assertion macros for the soft-disk pair force block.
// Both sample on aclk and are disabled while aresetn is low.
`ifndef SOFT_DISK_PAIR_FORCE_TOP_ASSERT_SVH
`define SOFT_DISK_PAIR_FORCE_TOP_ASSERT_SVH

// same-cycle implication
`define SDPF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sdpf assertion failed");

// next-cycle implication
`define SDPF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sdpf assertion failed");

`endif

[hw/rtl/sdpf_pkg.sv]
package sdpf_pkg;

    // fixed field widths
    localparam int POS_W    = 24;
    localparam int RAD_W    = 18;
    localparam int RSUM_W   = 19;
    localparam int FORCE_W  = 24;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 3;

    localparam int FRACTION_BITS_DEF = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LENGTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPULSION_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADHESION_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ADHESION_RANGE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_SQUARED = 3'd4;

    // register reset values
    localparam logic [CFG_W-1:0] RST_BOX_LENGTH     = 24'd5636096;
    localparam logic [CFG_W-1:0] RST_REPULSION_GAIN = 24'd1310720;
    localparam logic [CFG_W-1:0] RST_ADHESION_GAIN  = 24'd49152;
    localparam logic [CFG_W-1:0] RST_ADHESION_RANGE = 24'd21845;
    localparam logic [CFG_W-1:0] RST_CUTOFF_SQUARED = 24'd454455;

    // saturation limits
    localparam logic [FORCE_W-1:0] FORCE_POS_MAX = 24'h7FFFFF;
    localparam logic [FORCE_W-1:0] FORCE_NEG_MAG = 24'h800000;

    typedef enum logic [1:0] {
        KIND_NONE      = 2'd0,
        KIND_REPULSION = 2'd1,
        KIND_ADHESION  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [POS_W-1:0] first_x;
        logic [POS_W-1:0] first_y;
        logic [POS_W-1:0] second_x;
        logic [POS_W-1:0] second_y;
        logic [RAD_W-1:0] first_radius;
        logic [RAD_W-1:0] second_radius;
    } in_t;

    typedef struct packed {
        logic signed [FORCE_W-1:0] force_x;
        logic signed [FORCE_W-1:0] force_y;
        kind_t                     interaction;
    } out_t;

endpackage

[hw/rtl/soft_disk_pair_force_top.sv]
// Soft-disk pair force engine: one request (two particle positions in a periodic
// box and two radii) per cycle in while s_ready is high, one force result per
// request out, in order. Throughput is one request per clock while the skid
// register is empty. The datapath runs through the 24-step minimum-image remainder
// pipeline, the square-root pipeline (one root bit per stage) and the 24-step
// force division pipeline. A skid register behind the output register lets the
// block take requests while one result waits. Configuration is always ready and
// must only be written while no request is in flight.
module soft_disk_pair_force_top #(
    parameter int FRACTION_BITS = sdpf_pkg::FRACTION_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  sdpf_pkg::in_t                       s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output sdpf_pkg::out_t                      m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sdpf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sdpf_pkg::CFG_W-1:0]          cfg_data
);

    localparam int PW  = sdpf_pkg::POS_W;
    localparam int RW_SUM = sdpf_pkg::RSUM_W;
    localparam int D2W = 2 * PW + 1;                     // squared distance
    localparam int DW  = (PW + FRACTION_BITS + 1) / 2;   // root width
    localparam int VW  = 2 * DW;                          // root operand
    localparam int SW  = DW + 3;                          // root remainder
    localparam int RW  = DW + 1;                          // divider remainder
    localparam int EW  = PW + 1;                          // gap compare
    localparam int MW  = 2 * PW;                          // magnitude
    localparam int NW  = 3 * PW;                          // force numerator

    // valid bit positions along the pipeline
    localparam int V_FIX  = PW + 1;
    localparam int V_SQ   = V_FIX + 1;
    localparam int V_RT0  = V_SQ + 1;
    localparam int V_GAP  = V_RT0 + DW + 1;
    localparam int V_MAG  = V_GAP + 1;
    localparam int V_PP   = V_MAG + 1;
    localparam int V_DV0  = V_PP + 1;
    localparam int NST    = V_DV0 + PW + 1;

    typedef struct packed {
        logic [PW-1:0]     magx;
        logic [PW-1:0]     magy;
        logic [PW-1:0]     remx;
        logic [PW-1:0]     remy;
        logic              qx;
        logic              qy;
        logic              negx;
        logic              negy;
        logic [RW_SUM-1:0] rsum;
    } wrap_t;

    typedef struct packed {
        logic [PW-1:0]     adx;
        logic [PW-1:0]     ady;
        logic              sx;
        logic              sy;
        logic              wrapped;
        logic [RW_SUM-1:0] rsum;
    } ctx_t;

    typedef struct packed {
        ctx_t         ctx;
        logic [MW-1:0] sqx;
        logic [MW-1:0] sqy;
    } sq_t;

    typedef struct packed {
        ctx_t          ctx;
        logic          kill;
        logic [VW-1:0] v;
        logic [SW-1:0] rem;
        logic [DW-1:0] root;
    } rt_t;

    typedef struct packed {
        ctx_t               ctx;
        logic [DW-1:0]      dist_len;
        sdpf_pkg::kind_t    kind;
        logic [PW-1:0]      fac;
        logic [PW-1:0]      gain;
    } gap_t;

    typedef struct packed {
        ctx_t               ctx;
        logic [DW-1:0]      dist_len;
        sdpf_pkg::kind_t    kind;
        logic [MW-1:0]      mag;
    } mag_t;

    typedef struct packed {
        logic               sx;
        logic               sy;
        logic [DW-1:0]      dist_len;
        sdpf_pkg::kind_t    kind;
        logic [MW-1:0]      pxl;
        logic [MW-1:0]      pxh;
        logic [MW-1:0]      pyl;
        logic [MW-1:0]      pyh;
    } pp_t;

    typedef struct packed {
        logic               sx;
        logic               sy;
        logic [DW-1:0]      dist_len;
        sdpf_pkg::kind_t    kind;
        logic               ovx;
        logic               ovy;
        logic [RW-1:0]      remx;
        logic [RW-1:0]      remy;
        logic [PW-1:0]      lowx;
        logic [PW-1:0]      lowy;
        logic [PW-1:0]      qx;
        logic [PW-1:0]      qy;
    } div_t;

    // configuration registers
    logic [sdpf_pkg::CFG_W-1:0] box_length_reg;
    logic [sdpf_pkg::CFG_W-1:0] repulsion_gain_reg;
    logic [sdpf_pkg::CFG_W-1:0] adhesion_gain_reg;
    logic [sdpf_pkg::CFG_W-1:0] adhesion_range_reg;
    logic [sdpf_pkg::CFG_W-1:0] cutoff_squared_reg;

    logic [NST-1:0]  stage_valid_reg;
    wrap_t           wrap_reg [0:PW];
    ctx_t            fix_reg;
    sq_t             sq_reg;
    rt_t             rt_reg [0:DW];
    gap_t            gap_reg;
    mag_t            mag_reg;
    pp_t             pp_reg;
    div_t            div_reg [0:PW];

    logic            m_valid_reg;
    logic            skid_valid_reg;
    sdpf_pkg::out_t  out_reg;
    sdpf_pkg::out_t  skid_reg;
    sdpf_pkg::out_t  res;
    logic            en;

    assign en        = !skid_valid_reg;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_length_reg     <= sdpf_pkg::RST_BOX_LENGTH;
            repulsion_gain_reg <= sdpf_pkg::RST_REPULSION_GAIN;
            adhesion_gain_reg  <= sdpf_pkg::RST_ADHESION_GAIN;
            adhesion_range_reg <= sdpf_pkg::RST_ADHESION_RANGE;
            cutoff_squared_reg <= sdpf_pkg::RST_CUTOFF_SQUARED;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                sdpf_pkg::CFG_BOX_LENGTH:     box_length_reg     <= cfg_data;
                sdpf_pkg::CFG_REPULSION_GAIN: repulsion_gain_reg <= cfg_data;
                sdpf_pkg::CFG_ADHESION_GAIN:  adhesion_gain_reg  <= cfg_data;
                sdpf_pkg::CFG_ADHESION_RANGE: adhesion_range_reg <= cfg_data;
                sdpf_pkg::CFG_CUTOFF_SQUARED: cutoff_squared_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits shift with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= '0;
        end else if (en) begin
            stage_valid_reg <= {stage_valid_reg[NST-2:0], s_valid};
        end
    end

    // input stage: absolute differences and radius sum
    wrap_t           wrap_in_next;
    logic [PW:0]     diff_x;
    logic [PW:0]     diff_y;
    always_comb begin
        diff_x = {1'b0, s_data.first_x} - {1'b0, s_data.second_x};
        diff_y = {1'b0, s_data.first_y} - {1'b0, s_data.second_y};
        wrap_in_next.negx = diff_x[PW];
        wrap_in_next.negy = diff_y[PW];
        wrap_in_next.magx = diff_x[PW] ? PW'(-diff_x) : diff_x[PW-1:0];
        wrap_in_next.magy = diff_y[PW] ? PW'(-diff_y) : diff_y[PW-1:0];
        wrap_in_next.remx = '0;
        wrap_in_next.remy = '0;
        wrap_in_next.qx   = 1'b0;
        wrap_in_next.qy   = 1'b0;
        wrap_in_next.rsum = {1'b0, s_data.first_radius} + {1'b0, s_data.second_radius};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            wrap_reg[0] <= wrap_in_next;
        end
    end

    // remainder modulo the box, one quotient bit per stage
    for (genvar k = 0; k < PW; k++) begin : g_wrap
        wrap_t       wrap_next;
        logic [PW:0] shx;
        logic [PW:0] shy;
        always_comb begin
            wrap_next = wrap_reg[k];
            shx = {wrap_reg[k].remx, wrap_reg[k].magx[PW-1-k]};
            shy = {wrap_reg[k].remy, wrap_reg[k].magy[PW-1-k]};
            if (shx >= {1'b0, box_length_reg}) begin
                wrap_next.remx = PW'(shx - {1'b0, box_length_reg});
                wrap_next.qx   = 1'b1;
            end else begin
                wrap_next.remx = shx[PW-1:0];
            end
            if (shy >= {1'b0, box_length_reg}) begin
                wrap_next.remy = PW'(shy - {1'b0, box_length_reg});
                wrap_next.qy   = 1'b1;
            end else begin
                wrap_next.remy = shy[PW-1:0];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                wrap_reg[k+1] <= wrap_next;
            end
        end
    end

    // round to the nearest image; a remainder of at least half the box flips side
    ctx_t  fix_next;
    logic  box_nz;
    logic  upx;
    logic  upy;
    always_comb begin
        box_nz = box_length_reg != '0;
        upx = box_nz && ({wrap_reg[PW].remx, 1'b0} >= {1'b0, box_length_reg});
        upy = box_nz && ({wrap_reg[PW].remy, 1'b0} >= {1'b0, box_length_reg});
        fix_next.adx = upx ? box_length_reg - wrap_reg[PW].remx : wrap_reg[PW].remx;
        fix_next.ady = upy ? box_length_reg - wrap_reg[PW].remy : wrap_reg[PW].remy;
        fix_next.sx  = upx ? !wrap_reg[PW].negx : wrap_reg[PW].negx;
        fix_next.sy  = upy ? !wrap_reg[PW].negy : wrap_reg[PW].negy;
        fix_next.wrapped = upx || upy
                        || (box_nz && (wrap_reg[PW].qx || wrap_reg[PW].qy));
        fix_next.rsum = wrap_reg[PW].rsum;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fix_reg <= fix_next;
        end
    end

    // squares
    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg.ctx <= fix_reg;
            sq_reg.sqx <= fix_reg.adx * fix_reg.adx;
            sq_reg.sqy <= fix_reg.ady * fix_reg.ady;
        end
    end

    // squared distance, cutoff and zero checks
    rt_t            rt_in_next;
    logic [D2W-1:0] dist2;
    always_comb begin
        dist2 = {1'b0, sq_reg.sqx} + {1'b0, sq_reg.sqy};
        rt_in_next.ctx  = sq_reg.ctx;
        rt_in_next.kill = (dist2 > (D2W'(cutoff_squared_reg) << FRACTION_BITS))
                       || (dist2 == '0);
        rt_in_next.v    = dist2[VW-1:0];
        rt_in_next.rem  = '0;
        rt_in_next.root = '0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rt_reg[0] <= rt_in_next;
        end
    end

    // integer square root, one root bit per stage
    for (genvar k = 0; k < DW; k++) begin : g_root
        rt_t           rt_next;
        logic [SW-1:0] rem_s;
        logic [SW-1:0] trial;
        always_comb begin
            rt_next = rt_reg[k];
            rem_s = {rt_reg[k].rem[SW-3:0], rt_reg[k].v[VW-1-2*k -: 2]};
            trial = {1'b0, rt_reg[k].root, 2'b01};
            if (rem_s >= trial) begin
                rt_next.rem  = rem_s - trial;
                rt_next.root = {rt_reg[k].root[DW-2:0], 1'b1};
            end else begin
                rt_next.rem  = rem_s;
                rt_next.root = {rt_reg[k].root[DW-2:0], 1'b0};
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rt_reg[k+1] <= rt_next;
            end
        end
    end

    // overlap or adhesive gap selection
    gap_t          gap_next;
    logic [EW-1:0] dist_e;
    logic [EW-1:0] rsum_e;
    always_comb begin
        dist_e = EW'(rt_reg[DW].root);
        rsum_e = EW'(rt_reg[DW].ctx.rsum);
        gap_next.ctx  = rt_reg[DW].ctx;
        gap_next.dist_len = rt_reg[DW].root;
        gap_next.kind = sdpf_pkg::KIND_NONE;
        gap_next.fac  = '0;
        gap_next.gain = '0;
        priority if (rt_reg[DW].kill) begin
            gap_next.kind = sdpf_pkg::KIND_NONE;
        end else if (dist_e < rsum_e) begin
            gap_next.kind = sdpf_pkg::KIND_REPULSION;
            gap_next.fac  = PW'(rsum_e - dist_e);
            gap_next.gain = repulsion_gain_reg;
        end else if (!rt_reg[DW].ctx.wrapped
                     && ((dist_e - rsum_e) < EW'(adhesion_range_reg))) begin
            gap_next.kind = sdpf_pkg::KIND_ADHESION;
            gap_next.fac  = PW'(dist_e - rsum_e);
            gap_next.gain = adhesion_gain_reg;
        end else begin
            gap_next.kind = sdpf_pkg::KIND_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            gap_reg <= gap_next;
        end
    end

    // force magnitude
    logic [MW-1:0] mag_prod;
    assign mag_prod = gap_reg.fac * gap_reg.gain;

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg.ctx  <= gap_reg.ctx;
            mag_reg.dist_len <= gap_reg.dist_len;
            mag_reg.kind <= gap_reg.kind;
            mag_reg.mag  <= mag_prod >> FRACTION_BITS;
        end
    end

    // |d| * magnitude as two partial products per axis
    always_ff @(posedge aclk) begin
        if (en) begin
            pp_reg.sx   <= mag_reg.ctx.sx;
            pp_reg.sy   <= mag_reg.ctx.sy;
            pp_reg.dist_len <= mag_reg.dist_len;
            pp_reg.kind <= mag_reg.kind;
            pp_reg.pxl  <= mag_reg.ctx.adx * mag_reg.mag[PW-1:0];
            pp_reg.pxh  <= mag_reg.ctx.adx * mag_reg.mag[MW-1:PW];
            pp_reg.pyl  <= mag_reg.ctx.ady * mag_reg.mag[PW-1:0];
            pp_reg.pyh  <= mag_reg.ctx.ady * mag_reg.mag[MW-1:PW];
        end
    end

    // numerator assembly and quotient overflow check
    div_t          div_in_next;
    logic [NW-1:0] num_x;
    logic [NW-1:0] num_y;
    always_comb begin
        num_x = {{PW{1'b0}}, pp_reg.pxl} + {pp_reg.pxh, {PW{1'b0}}};
        num_y = {{PW{1'b0}}, pp_reg.pyl} + {pp_reg.pyh, {PW{1'b0}}};
        div_in_next.sx   = pp_reg.sx;
        div_in_next.sy   = pp_reg.sy;
        div_in_next.dist_len = pp_reg.dist_len;
        div_in_next.kind = pp_reg.kind;
        div_in_next.ovx  = num_x[NW-1:PW] >= MW'(pp_reg.dist_len);
        div_in_next.ovy  = num_y[NW-1:PW] >= MW'(pp_reg.dist_len);
        div_in_next.remx = num_x[PW+RW-1:PW];
        div_in_next.remy = num_y[PW+RW-1:PW];
        div_in_next.lowx = num_x[PW-1:0];
        div_in_next.lowy = num_y[PW-1:0];
        div_in_next.qx   = '0;
        div_in_next.qy   = '0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            div_reg[0] <= div_in_next;
        end
    end

    // divide by distance, one quotient bit per stage
    for (genvar k = 0; k < PW; k++) begin : g_div
        div_t          div_next;
        logic [RW-1:0] shx;
        logic [RW-1:0] shy;
        logic [RW-1:0] dv;
        always_comb begin
            div_next = div_reg[k];
            dv  = RW'(div_reg[k].dist_len);
            shx = {div_reg[k].remx[DW-1:0], div_reg[k].lowx[PW-1-k]};
            shy = {div_reg[k].remy[DW-1:0], div_reg[k].lowy[PW-1-k]};
            if (shx >= dv) begin
                div_next.remx = shx - dv;
                div_next.qx   = {div_reg[k].qx[PW-2:0], 1'b1};
            end else begin
                div_next.remx = shx;
                div_next.qx   = {div_reg[k].qx[PW-2:0], 1'b0};
            end
            if (shy >= dv) begin
                div_next.remy = shy - dv;
                div_next.qy   = {div_reg[k].qy[PW-2:0], 1'b1};
            end else begin
                div_next.remy = shy;
                div_next.qy   = {div_reg[k].qy[PW-2:0], 1'b0};
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                div_reg[k+1] <= div_next;
            end
        end
    end

    // sign and saturation
    logic neg_x;
    logic neg_y;
    logic adh;
    always_comb begin
        adh   = div_reg[PW].kind == sdpf_pkg::KIND_ADHESION;
        neg_x = div_reg[PW].sx ^ adh;
        neg_y = div_reg[PW].sy ^ adh;
        res.interaction = div_reg[PW].kind;
        if (div_reg[PW].kind == sdpf_pkg::KIND_NONE) begin
            res.force_x = '0;
        end else if (neg_x) begin
            res.force_x = (div_reg[PW].ovx || div_reg[PW].qx > sdpf_pkg::FORCE_NEG_MAG)
                        ? sdpf_pkg::FORCE_NEG_MAG : -div_reg[PW].qx;
        end else begin
            res.force_x = (div_reg[PW].ovx || div_reg[PW].qx[PW-1])
                        ? sdpf_pkg::FORCE_POS_MAX : div_reg[PW].qx;
        end
        if (div_reg[PW].kind == sdpf_pkg::KIND_NONE) begin
            res.force_y = '0;
        end else if (neg_y) begin
            res.force_y = (div_reg[PW].ovy || div_reg[PW].qy > sdpf_pkg::FORCE_NEG_MAG)
                        ? sdpf_pkg::FORCE_NEG_MAG : -div_reg[PW].qy;
        end else begin
            res.force_y = (div_reg[PW].ovy || div_reg[PW].qy[PW-1])
                        ? sdpf_pkg::FORCE_POS_MAX : div_reg[PW].qy;
        end
    end

    // output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg <= stage_valid_reg[NST-1];
        end else if (stage_valid_reg[NST-1]) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_ready) begin
                out_reg <= skid_reg;
            end
        end else if (!m_valid_reg || m_ready) begin
            out_reg <= res;
        end else begin
            skid_reg <= res;
        end
    end

`include "soft_disk_pair_force_top_assert.svh"

    `SDPF_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, m_valid_reg)
    `SDPF_ASSERT_IMP(a_skid_fill_on_stall, $rose(skid_valid_reg), $past(m_valid_reg && !m_ready))
    `SDPF_ASSERT_IMP(a_none_zero_force, m_valid_reg && (out_reg.interaction == sdpf_pkg::KIND_NONE), (out_reg.force_x == '0) && (out_reg.force_y == '0))
    `SDPF_ASSERT_NEXT(a_skid_drain, skid_valid_reg && m_ready, !skid_valid_reg && m_valid_reg)

endmodule
